### hw/rtl/ring_of_bump_buffers_allocator_unit_macros.svh
// Assertion macros for the checker of the allocator.
`ifndef RING_OF_BUMP_BUFFERS_ALLOCATOR_UNIT_MACROS_SVH
`define RING_OF_BUMP_BUFFERS_ALLOCATOR_UNIT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RBBA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni of the unit.
`define RBBA_ASSERT(label, prop, msg) \
  `RBBA_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/rbba_pkg.sv
package rbba_pkg;

  localparam int unsigned SizeW      = 33;
  localparam int unsigned GenW       = 32;
  localparam int unsigned AlignW     = 17;
  localparam int unsigned ReqW       = 32;
  localparam int unsigned SlotOutW   = 3;
  localparam int unsigned MaxResults = 8;
  localparam int unsigned CntW       = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 33;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgInitialSize = cfg_idx_t'(0);
  localparam cfg_idx_t CfgGrowthCap   = cfg_idx_t'(1);
  localparam cfg_idx_t CfgStaleAge    = cfg_idx_t'(2);

  localparam logic [SizeW-1:0] InitialSizeRst = SizeW'(16777216);
  localparam logic [SizeW-1:0] GrowthCapRst   = SizeW'(536870912);
  localparam logic [GenW-1:0]  StaleAgeRst    = GenW'(500);

  localparam logic KindAlloc = 1'b0;
  localparam logic KindScan  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [GenW-1:0]   generation;
    logic [AlignW-1:0] alignment;
    logic [ReqW-1:0]   size_in_bytes;
  } rbba_in_t;

  typedef struct packed {
    logic                ok;
    logic [SlotOutW-1:0] slot;
    logic [SizeW-1:0]    offset;
    logic                resized;
    logic                last;
  } rbba_out_t;

  // One ring slot as held in the slot store.
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] fill;
    logic [GenW-1:0]  last_used;
  } rbba_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } rbba_mem_ctl_t;

  typedef enum logic [2:0] {
    StIdle,
    StFit,
    StGrow,
    StAlign,
    StEnd,
    StScan,
    StScanEnd
  } rbba_state_e;

endpackage

### hw/rtl/ring_of_bump_buffers_allocator_unit.sv
// An allocation's result is registered in StEnd once the output is free: after StFit and
// StAlign when the current buffer is reused, or after StFit, StGrow and StAlign when a new
// ring slot is opened, StGrow doing the size doublings (at most 33) one per cycle. A scan
// reads one slot per cycle in StScan unless a stale slot waits on a full output, and loads
// its last result in StScanEnd. One item at a time; the next is taken after it is loaded.
// Reset clears all slots, the ring pointers and the output, and loads the default registers.
module ring_of_bump_buffers_allocator_unit #(
  parameter int unsigned RING_SLOTS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rbba_pkg::rbba_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rbba_pkg::rbba_out_t              out_data_o,
  input  logic                             cfg_we_i,
  input  rbba_pkg::cfg_idx_t               cfg_idx_i,
  input  logic [rbba_pkg::CfgDataW-1:0]    cfg_data_i
);
  import rbba_pkg::*;

  localparam int unsigned SlotW = $clog2(RING_SLOTS);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(RING_SLOTS - 1);

  // Narrows a ring slot number to the slot field of a result.
  function automatic logic [SlotOutW-1:0] slot_out(input logic [SlotW-1:0] s);
    logic [SlotW+SlotOutW-1:0] wide;
    wide = (SlotW + SlotOutW)'(s);
    return wide[SlotOutW-1:0];
  endfunction

  // Configuration registers.
  logic [SizeW-1:0] cfg_init_q, cfg_cap_q;
  logic [GenW-1:0]  cfg_stale_q;

  // Sequencer and pool state.
  rbba_state_e      state_q, state_d;
  rbba_in_t         item_q, item_d;
  logic             have_cur_q, have_cur_d;
  logic [SlotW-1:0] cur_slot_q, cur_slot_d;
  logic [SlotW-1:0] next_slot_q, next_slot_d;
  logic [GenW-1:0]  pool_gen_q, pool_gen_d;
  logic [SizeW-1:0] prev_size_q, prev_size_d;

  // Working copy of the slot under allocation.
  logic [SizeW-1:0] size_q, size_d;
  logic [SizeW-1:0] fill_q, fill_d;
  logic [GenW-1:0]  lu_q, lu_d;
  logic [SizeW:0]   aligned_q, aligned_d;
  logic             resized_q, resized_d;

  // Scan walk: the most recent stale slot waits until it is known whether it is the last.
  logic [SlotW-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [SlotW-1:0] pend_slot_q, pend_slot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // Output register.
  logic             out_valid_q, out_load, out_free;
  rbba_out_t        out_q, out_d;

  // Slot store connections.
  rbba_mem_ctl_t    mem_ctl;
  logic [SlotW-1:0] rd_addr;
  rbba_entry_t      rd_data, wr_data;

  // Datapath terms.
  logic [SizeW:0]    dbl_prev;
  logic [SizeW-1:0]  capped, start_size;
  logic [SizeW:0]    fit_sum;
  logic              no_fit;
  logic [AlignW-1:0] align_mask;
  logic [SizeW:0]    align_sum;
  logic [SizeW+1:0]  end_sum;
  logic              fail;
  logic [GenW-1:0]   age;
  logic              stale, scan_end;

  rbba_slot_store #(
    .Slots (RING_SLOTS)
  ) u_slot_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_addr_i (cur_slot_q),
    .wr_data_i (wr_data)
  );

  // Configuration writes to an unknown index are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_init_q  <= InitialSizeRst;
      cfg_cap_q   <= GrowthCapRst;
      cfg_stale_q <= StaleAgeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgInitialSize: cfg_init_q  <= cfg_data_i;
        CfgGrowthCap:   cfg_cap_q   <= cfg_data_i;
        CfgStaleAge:    cfg_stale_q <= cfg_data_i[GenW-1:0];
        default: ;
      endcase
    end
  end

  // The starting size of a new slot is twice the previous size, held to the growth cap,
  // with the initial size taking over when that comes to zero.
  assign dbl_prev   = {prev_size_q, 1'b0};
  assign capped     = (dbl_prev > {1'b0, cfg_cap_q}) ? cfg_cap_q : dbl_prev[SizeW-1:0];
  assign start_size = (capped == '0) ? cfg_init_q : capped;

  // The current buffer is kept only if the unaligned request still fits behind its fill.
  assign fit_sum = {1'b0, rd_data.fill} + (SizeW + 1)'(item_q.size_in_bytes);
  assign no_fit  = fit_sum > {1'b0, rd_data.size};

  // An alignment of zero behaves as an alignment of one.
  assign align_mask = (item_q.alignment == '0) ? '0 : item_q.alignment - AlignW'(1);
  assign align_sum  = {1'b0, fill_q} + (SizeW + 1)'(align_mask);

  assign end_sum = {1'b0, aligned_q} + (SizeW + 2)'(item_q.size_in_bytes);
  assign fail    = end_sum > (SizeW + 2)'(size_q);

  // Ages wrap modulo two to the power of the generation width.
  assign age      = item_q.generation - rd_data.last_used;
  assign stale    = (rd_data.size != '0) && (age > cfg_stale_q);
  assign scan_end = (idx_q == LastSlot) || (stale && (cnt_q == CntW'(MaxResults - 1)));

  assign out_free = !out_valid_q || out_ready_i;

  // A failed allocation keeps the fill and stamp, but a new size and cleared fill remain.
  always_comb begin
    wr_data.size      = size_q;
    wr_data.fill      = fail ? fill_q : end_sum[SizeW-1:0];
    wr_data.last_used = fail ? lu_q : item_q.generation;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    have_cur_d  = have_cur_q;
    cur_slot_d  = cur_slot_q;
    next_slot_d = next_slot_q;
    pool_gen_d  = pool_gen_q;
    prev_size_d = prev_size_q;
    size_d      = size_q;
    fill_d      = fill_q;
    lu_d        = lu_q;
    aligned_d   = aligned_q;
    resized_d   = resized_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    cnt_d       = cnt_q;
    out_load    = 1'b0;
    out_d       = out_q;
    mem_ctl     = '0;
    rd_addr     = cur_slot_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_data_i;
          mem_ctl.rd_en = 1'b1;
          if (in_data_i.kind == KindAlloc) begin
            // A new generation drops the current buffer.
            pool_gen_d = in_data_i.generation;
            have_cur_d = have_cur_q && (pool_gen_q == in_data_i.generation);
            rd_addr    = cur_slot_q;
            resized_d  = 1'b0;
            state_d    = StFit;
          end else begin
            rd_addr = '0;
            idx_d   = '0;
            pend_d  = 1'b0;
            cnt_d   = '0;
            state_d = StScan;
          end
        end
      end

      StFit: begin
        if (have_cur_q && !no_fit) begin
          size_d  = rd_data.size;
          fill_d  = rd_data.fill;
          lu_d    = rd_data.last_used;
          state_d = StAlign;
        end else begin
          cur_slot_d    = next_slot_q;
          have_cur_d    = 1'b1;
          next_slot_d   = (next_slot_q == LastSlot) ? '0 : next_slot_q + SlotW'(1);
          rd_addr       = next_slot_q;
          mem_ctl.rd_en = 1'b1;
          size_d        = start_size;
          state_d       = StGrow;
        end
      end

      StGrow: begin
        // One doubling per cycle until the request fits; zero grows to one.
        if (size_q < SizeW'(item_q.size_in_bytes)) begin
          size_d = (size_q == '0) ? SizeW'(1) : {size_q[SizeW-2:0], 1'b0};
        end else begin
          resized_d   = rd_data.size != size_q;
          fill_d      = '0;
          lu_d        = rd_data.last_used;
          prev_size_d = size_q;
          state_d     = StAlign;
        end
      end

      StAlign: begin
        aligned_d = align_sum & ~((SizeW + 1)'(align_mask));
        state_d   = StEnd;
      end

      StEnd: begin
        if (out_free) begin
          mem_ctl.wr_en = 1'b1;
          out_load      = 1'b1;
          out_d.ok      = !fail;
          out_d.slot    = slot_out(cur_slot_q);
          out_d.offset  = fail ? '0 : aligned_q[SizeW-1:0];
          out_d.resized = resized_q;
          out_d.last    = 1'b1;
          state_d       = StIdle;
        end
      end

      StScan: begin
        // A second stale slot must wait while the one before it cannot yet leave.
        if (!(stale && pend_q && !out_free)) begin
          if (stale) begin
            if (pend_q) begin
              out_load      = 1'b1;
              out_d.ok      = 1'b1;
              out_d.slot    = slot_out(pend_slot_q);
              out_d.offset  = '0;
              out_d.resized = 1'b0;
              out_d.last    = 1'b0;
            end
            pend_d      = 1'b1;
            pend_slot_d = idx_q;
            cnt_d       = cnt_q + CntW'(1);
          end
          if (scan_end) begin
            state_d = StScanEnd;
          end else begin
            idx_d         = idx_q + SlotW'(1);
            rd_addr       = idx_q + SlotW'(1);
            mem_ctl.rd_en = 1'b1;
          end
        end
      end

      StScanEnd: begin
        // With no stale slot, a single empty item closes the scan.
        if (out_free) begin
          out_load      = 1'b1;
          out_d.ok      = pend_q;
          out_d.slot    = pend_q ? slot_out(pend_slot_q) : '0;
          out_d.offset  = '0;
          out_d.resized = 1'b0;
          out_d.last    = 1'b1;
          state_d       = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      have_cur_q  <= 1'b0;
      cur_slot_q  <= '0;
      next_slot_q <= '0;
      pool_gen_q  <= '0;
      prev_size_q <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_cur_q  <= have_cur_d;
      cur_slot_q  <= cur_slot_d;
      next_slot_q <= next_slot_d;
      pool_gen_q  <= pool_gen_d;
      prev_size_q <= prev_size_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    size_q      <= size_d;
    fill_q      <= fill_d;
    lu_q        <= lu_d;
    aligned_q   <= aligned_d;
    resized_q   <= resized_d;
    pend_slot_q <= pend_slot_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/rbba_slot_store.sv
module rbba_slot_store #(
  parameter int unsigned Slots = 8,
  localparam int unsigned SlotW = $clog2(Slots)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rbba_pkg::rbba_mem_ctl_t ctl_i,
  input  logic [SlotW-1:0]      rd_addr_i,
  output rbba_pkg::rbba_entry_t rd_data_o,
  input  logic [SlotW-1:0]      wr_addr_i,
  input  rbba_pkg::rbba_entry_t wr_data_i
);
  import rbba_pkg::*;

  rbba_entry_t            mem_q [Slots];
  logic [Slots-1:0]       valid_q;
  rbba_entry_t            rd_data_q;

  // A slot that was never written reads as all zeroes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr_en) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/rbba_checker.sv
`include "ring_of_bump_buffers_allocator_unit_macros.svh"

module rbba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input rbba_pkg::rbba_out_t           out_data_o
);
  import rbba_pkg::*;

  // A result that is not taken stays on the port unchanged.
  `RBBA_ASSERT(a_out_hold,
               out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o),
               "result changed while stalled")

  // Only one item is worked on at a time.
  `RBBA_ASSERT(a_busy_after_accept,
               in_valid_i && in_ready_o |=> !in_ready_o,
               "accepted a second item while busy")

  // An item that is not ok always closes its input and carries no offset.
  `RBBA_ASSERT(a_fail_is_last,
               out_valid_o && !out_data_o.ok |-> out_data_o.last && out_data_o.offset == '0,
               "unsuccessful item not final or with an offset")

  // Only scans give more than one item, and their entries carry no offset or resize.
  `RBBA_ASSERT(a_scan_entry,
               out_valid_o && !out_data_o.last |->
                 out_data_o.ok && out_data_o.offset == '0 && !out_data_o.resized,
               "malformed non-final item")

endmodule

bind ring_of_bump_buffers_allocator_unit rbba_checker u_rbba_checker (.*);

### tb/ring_of_bump_buffers_allocator_unit_tb.sv
`timescale 1ns / 1ps

module ring_of_bump_buffers_allocator_unit_tb;
  import rbba_pkg::*;

  // The ring is left at its default depth, so every slot number fits the 3-bit field.
  localparam int unsigned Slots      = 8;
  localparam int unsigned CycleLimit = 600000;
  // Writes to this index must leave every register as it was.
  localparam cfg_idx_t    CfgSpare   = cfg_idx_t'(3);

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  rbba_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rbba_out_t           out_data;
  logic                cfg_we    = 1'b0;
  cfg_idx_t            cfg_idx   = CfgInitialSize;
  logic [CfgDataW-1:0] cfg_data  = '0;

  ring_of_bump_buffers_allocator_unit #(
    .RING_SLOTS(Slots)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #2 clk = ~clk;

  // Our own copy of the allocator state, advanced once per accepted item.
  logic             cur_valid;
  int unsigned      cur_slot;
  int unsigned      nxt_slot;
  logic [GenW-1:0]  frame_gen;
  logic [SizeW-1:0] last_size;
  logic [SizeW-1:0] ring_size  [Slots];
  logic [SizeW-1:0] ring_fill  [Slots];
  logic [GenW-1:0]  ring_stamp [Slots];

  // Register values as the block should hold them.
  logic [SizeW-1:0] cfg_initial_size;
  logic [SizeW-1:0] cfg_growth_cap;
  logic [GenW-1:0]  cfg_stale_age;

  // Results still owed by the block, oldest first.
  rbba_out_t replies_due[$];

  // Generation that well-formed traffic advances slowly, so that buffers are reused.
  logic [GenW-1:0] frame_clock;

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned replies_seen;
  int unsigned n_alloc_ok;
  int unsigned n_alloc_fail;
  int unsigned n_resized;
  int unsigned n_scans;
  int unsigned n_stale;

  // Idling control shared by the sender and the receiver.
  logic        idle_on      = 1'b1;
  logic        hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    end
  endtask

  // An allocation either continues the current buffer or opens the next ring slot, growing
  // its size until the request fits; the aligned region is then bumped into the buffer.
  function automatic void predict_allocation(rbba_in_t item);
    logic [63:0] req;
    logic [63:0] size;
    logic [63:0] amask;
    logic [63:0] aligned;
    logic [63:0] fin;
    rbba_out_t   r;
    req = 64'(item.size_in_bytes);
    r = '0;
    if (frame_gen != item.generation) begin
      cur_valid = 1'b0;
      frame_gen = item.generation;
    end
    if (cur_valid && (64'(ring_fill[cur_slot]) + req > 64'(ring_size[cur_slot]))) begin
      cur_valid = 1'b0;
    end
    if (!cur_valid) begin
      cur_slot  = nxt_slot;
      cur_valid = 1'b1;
      nxt_slot  = (cur_slot + 1) % Slots;
      size = 64'(last_size) << 1;
      if (size > 64'(cfg_growth_cap)) begin
        size = 64'(cfg_growth_cap);
      end
      if (size == 64'd0) begin
        size = 64'(cfg_initial_size);
      end
      // A zero size first becomes one, and a zero request leaves it at zero.
      while (size < req) begin
        size = (size == 64'd0) ? 64'd1 : (size << 1);
      end
      last_size = size[SizeW-1:0];
      if (ring_size[cur_slot] != size[SizeW-1:0]) begin
        ring_size[cur_slot] = size[SizeW-1:0];
        r.resized = 1'b1;
        n_resized++;
      end
      ring_fill[cur_slot] = '0;
    end
    // A zero alignment acts as one; other values round up by clearing the mask bits.
    amask   = (item.alignment == '0) ? 64'd0 : 64'(item.alignment) - 64'd1;
    aligned = (64'(ring_fill[cur_slot]) + amask) & ~amask;
    fin     = aligned + req;
    r.slot  = 3'(cur_slot);
    r.last  = 1'b1;
    if (fin > 64'(ring_size[cur_slot])) begin
      n_alloc_fail++;
    end else begin
      ring_fill[cur_slot]  = fin[SizeW-1:0];
      ring_stamp[cur_slot] = item.generation;
      r.ok     = 1'b1;
      r.offset = aligned[SizeW-1:0];
      n_alloc_ok++;
    end
    replies_due.push_back(r);
  endfunction

  // A scan lists up to MaxResults sized slots idle for more than the stale age, lowest first, or
  // gives a single empty entry when none qualifies.
  function automatic void predict_scan(logic [GenW-1:0] gen);
    logic [GenW-1:0] age;
    int unsigned     total;
    int unsigned     k;
    rbba_out_t       r;
    total = 0;
    k = 0;
    for (int i = 0; i < Slots; i++) begin
      age = gen - ring_stamp[i];
      if (ring_size[i] != '0 && age > cfg_stale_age && total < MaxResults) begin
        total++;
      end
    end
    n_scans++;
    n_stale += total;
    for (int i = 0; i < Slots; i++) begin
      age = gen - ring_stamp[i];
      if (ring_size[i] != '0 && age > cfg_stale_age && k < total) begin
        r = '0;
        r.ok   = 1'b1;
        r.slot = 3'(i);
        r.last = (k == total - 1);
        replies_due.push_back(r);
        k++;
      end
    end
    if (total == 0) begin
      r = '0;
      r.last = 1'b1;
      replies_due.push_back(r);
    end
  endfunction

  // Offers one item, possibly after a burst of idle cycles, and predicts its results as soon
  // as it is taken. Valid is left high on return so that a following item keeps it up.
  task automatic send_request(logic kind, logic [GenW-1:0] gen, logic [AlignW-1:0] align,
                              logic [ReqW-1:0] bytes);
    rbba_in_t item;
    item.kind          = kind;
    item.generation    = gen;
    item.alignment     = align;
    item.size_in_bytes = bytes;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KindScan) begin
      predict_scan(gen);
    end else begin
      predict_allocation(item);
    end
    @(negedge clk);
  endtask

  // Drops valid and waits until every owed result has come out, then lets the block's longest
  // latency pass so that nothing is still being worked on.
  task automatic settle();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Writes all three registers while the block is idle, plus one write to the unused index
  // carrying all ones. The stale age write also carries a set top bit, which must be dropped.
  task automatic configure(logic [SizeW-1:0] init_size, logic [SizeW-1:0] cap,
                           logic [GenW-1:0] stale_gens);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgInitialSize;
    cfg_data <= init_size;
    @(negedge clk);
    cfg_idx  <= CfgGrowthCap;
    cfg_data <= cap;
    @(negedge clk);
    cfg_idx  <= CfgStaleAge;
    cfg_data <= {1'b1, stale_gens};
    @(negedge clk);
    cfg_idx  <= CfgSpare;
    cfg_data <= '1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_initial_size = init_size;
    cfg_growth_cap   = cap;
    cfg_stale_age    = stale_gens;
  endtask

  // Offsets, zero and odd alignments, a request of the largest size and a failed allocation,
  // all under the register values loaded by reset.
  task automatic test_default_allocations();
    send_request(KindAlloc, 32'd0, 17'd1, 32'd0);
    send_request(KindAlloc, 32'd0, 17'd0, 32'd100);
    send_request(KindAlloc, 32'd0, 17'd3, 32'd5);
    send_request(KindAlloc, 32'd0, 17'h10000, 32'd1);
    send_request(KindAlloc, 32'd0, 17'h1FFFF, 32'd1);
    send_request(KindAlloc, 32'd0, 17'd1, 32'hFFFF_FFFF);
    send_request(KindAlloc, 32'd1, 17'd1, 32'd10);
    // This one fits before alignment and overruns the buffer after it.
    send_request(KindAlloc, 32'd1, 17'h10000, 32'd536870902);
  endtask

  // Scans with nothing stale, with an age that wraps below zero, and at the top generation.
  task automatic test_stale_scans();
    send_request(KindScan, 32'd1, 17'd1, 32'd0);
    send_request(KindScan, 32'd0, 17'd1, 32'd0);
    send_request(KindScan, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
  endtask

  // A new generation per allocation walks the whole ring and wraps back onto slot zero,
  // after which every slot is sized and a scan reports all of them.
  task automatic test_ring_wrap();
    for (int g = 2; g < 8; g++) begin
      send_request(KindAlloc, 32'(g), 17'd1, 32'd1);
    end
    send_request(KindScan, 32'd2000, 17'd1, 32'd0);
    send_request(KindAlloc, 32'd7, 17'd1, 32'd0);
  endtask

  // With a zero start size and cap, a zero request keeps a zero buffer, and a real request
  // grows the buffer from one by doubling.
  task automatic test_zero_start_size();
    configure('0, '0, 32'd500);
    send_request(KindAlloc, 32'd40, 17'd1, 32'd0);
    send_request(KindAlloc, 32'd40, 17'd4, 32'd0);
    send_request(KindAlloc, 32'd40, 17'd1, 32'd1);
    send_request(KindAlloc, 32'd40, 17'd1, 32'd5);
  endtask

  // Mostly well-formed traffic: allocations at a slowly advancing generation and scans a
  // little later, some of them right at the stale boundary. The rest is noise with
  // arbitrary generations. Idling is switched on and off in stretches when allowed.
  task automatic test_random_mix(int count, logic may_idle);
    int unsigned       pick;
    int unsigned       scale;
    logic              kind;
    logic [GenW-1:0]   gen;
    logic [AlignW-1:0] align;
    logic [ReqW-1:0]   bytes;
    for (int k = 0; k < count; k++) begin
      if (k % 25 == 0) begin
        idle_on = may_idle && ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      scale = $urandom_range(0, 99);
      if (scale < 60) begin
        bytes = $urandom_range(0, 200);
      end else if (scale < 85) begin
        bytes = $urandom_range(0, 70000);
      end else if (scale < 95) begin
        bytes = $urandom_range(0, 1 << 24);
      end else begin
        bytes = $urandom;
      end
      scale = $urandom_range(0, 99);
      if (scale < 70) begin
        align = 17'd1 << $urandom_range(0, 6);
      end else if (scale < 90) begin
        align = 17'd1 << $urandom_range(0, 16);
      end else begin
        align = 17'($urandom_range(0, 17'h1FFFF));
      end
      kind = KindAlloc;
      if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) begin
          frame_clock = frame_clock + 32'($urandom_range(1, 3));
        end
        gen = frame_clock;
      end else if (pick < 80) begin
        kind = KindScan;
        gen = frame_clock + 32'($urandom_range(0, 40));
      end else if (pick < 90) begin
        kind = KindScan;
        gen = frame_clock + cfg_stale_age + 32'($urandom_range(0, 3)) - 32'd1;
      end else begin
        kind = (pick >= 95) ? KindScan : KindAlloc;
        gen = $urandom;
      end
      send_request(kind, gen, align, bytes);
    end
  endtask

  // The receiver refuses results for a long stretch while items keep being offered, so the
  // block fills up and has to hold its input off.
  task automatic test_output_hold_off();
    idle_on = 1'b0;
    hold_request = 1'b1;
    test_random_mix(30, 1'b0);
  endtask

  // The receiver: random stall bursts while idling is on, and a long hold-off on request.
  always @(negedge clk) begin : reply_sink
    logic take;
    take = 1'b1;
    if (hold_request) begin
      hold_left = 400;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (!idle_on) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      take = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      take = 1'b0;
    end
    out_ready <= take;
  end

  // Every result taken is compared field by field with the oldest one owed.
  always @(posedge clk) begin : reply_check
    rbba_out_t want;
    if (rst_n && out_valid && out_ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("result with none owed", 64'(out_data), 64'd0);
      end else begin
        want = replies_due.pop_front();
        if (out_data.ok !== want.ok) report_mismatch("ok", 64'(out_data.ok), 64'(want.ok));
        if (out_data.slot !== want.slot) begin
          report_mismatch("slot", 64'(out_data.slot), 64'(want.slot));
        end
        if (out_data.offset !== want.offset) begin
          report_mismatch("offset", 64'(out_data.offset), 64'(want.offset));
        end
        if (out_data.resized !== want.resized) begin
          report_mismatch("resized", 64'(out_data.resized), 64'(want.resized));
        end
        if (out_data.last !== want.last) begin
          report_mismatch("last", 64'(out_data.last), 64'(want.last));
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    cycles       = 0;
    mismatches   = 0;
    replies_seen = 0;
    n_alloc_ok   = 0;
    n_alloc_fail = 0;
    n_resized    = 0;
    n_scans      = 0;
    n_stale      = 0;
    cur_valid    = 1'b0;
    cur_slot     = 0;
    nxt_slot     = 0;
    frame_gen    = '0;
    last_size    = '0;
    frame_clock  = 32'd100;
    for (int i = 0; i < Slots; i++) begin
      ring_size[i]  = '0;
      ring_fill[i]  = '0;
      ring_stamp[i] = '0;
    end
    cfg_initial_size = InitialSizeRst;
    cfg_growth_cap   = GrowthCapRst;
    cfg_stale_age    = StaleAgeRst;

    // Reset is released on a falling edge, away from the rising edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_allocations();
    test_stale_scans();
    test_ring_wrap();
    test_zero_start_size();

    configure(33'd64, 33'd1024, 32'd4);
    test_random_mix(90, 1'b1);
    configure(33'd1, 33'h1_0000_0000, 32'd0);
    test_random_mix(70, 1'b1);
    configure(33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF);
    test_random_mix(50, 1'b1);
    configure(33'($urandom_range(1, 4096)), 33'($urandom_range(1, 1 << 20)),
              32'($urandom_range(0, 30)));
    test_output_hold_off();
    test_random_mix(30, 1'b1);
    // The last stretch runs flat out on both sides.
    configure(33'd32, 33'd256, 32'd2);
    test_random_mix(100, 1'b0);
    settle();

    $display("covered %0d allocations (%0d refused, %0d resizing) and %0d scans",
             n_alloc_ok + n_alloc_fail, n_alloc_fail, n_resized, n_scans);
    $display("%0d stale slot reports among %0d results checked over %0d cycles",
             n_stale, replies_seen, cycles);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
